// File: design/dhtc_pkg.sv
// Shared types and constants for the drying-oven heat timer controller.
// Used by the top level and by the restoring divider.
`default_nettype none
package dhtc_pkg;

	localparam int unsigned DIV_W = 32;	// remainder and aligned divisor width
	localparam int unsigned PCT_W = 7;	// percent quotient width
	localparam int unsigned QUO_W = PCT_W;	// widest quotient (percent done)
	localparam int unsigned CNT_W = 3;	// step counter, holds QUO_W

	localparam int unsigned MS_PER_SECOND = 1000;
	localparam int unsigned FULL_PERCENT  = 100;

	// ms to whole seconds: (ms * MS_RECIP) >> MS_RECIP_SHIFT, exact for 32-bit ms
	localparam int unsigned MS_RECIP       = 274877907;
	localparam int unsigned MS_RECIP_SHIFT = 38;

	typedef enum logic [1:0] {
		DRY_IDLE     = 2'd0,
		DRY_DRYING   = 2'd1,
		DRY_FINISHED = 2'd2,
		DRY_ERROR    = 2'd3
	} dryer_state_t;

	typedef enum logic [1:0] {
		MODE_UPDATE = 2'd0,
		MODE_START  = 2'd1,
		MODE_STOP   = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_TARGET_TEMP     = 3'd0,
		REG_HYSTERESIS_BAND = 3'd1,
		REG_HEATBED_LIMIT   = 3'd2,
		REG_CHAMBER_LIMIT   = 3'd3,
		REG_DRYING_SECONDS  = 3'd4
	} cfg_reg_t;

	// Divider request: divisor comes pre-aligned to the top quotient bit.
	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
		logic [CNT_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage
`default_nettype wire

// File: design/dryer_heat_timer_controller_top.sv
// Drying-oven controller: safety checks, run timer and heater hysteresis.
// Start, stop, mode 3, and an update without a run or failing the safety checks go
// straight to the done step; an update ending the run goes through the reciprocal
// multiply and the check; an update during a run adds 7 divider steps for percent.
// Input resumes once the result is loaded; a stalled result holds back the next one.
// Reset (arst_n low, asynchronous) restores register defaults and idle state.
`default_nettype none
module dryer_heat_timer_controller_top (
	input  wire         clk,
	input  wire         arst_n,
	// in: now_ms[31:0], chamber_temp[43:32], heatbed_temp[55:44],
	//     chamber_sensor_ok[56], heatbed_sensor_ok[57], zero pad
	input  wire  [63:0] s_axis_tdata,
	// in: mode[1:0]
	input  wire  [1:0]  s_axis_tuser,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	// out: dryer_state[1:0], heater_on[2], running[3], remaining_seconds[26:4],
	//      progress_percent[33:27], zero pad
	output logic [39:0] m_axis_tdata,
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	input  wire  [2:0]  cfg_index,
	input  wire  [22:0] cfg_data,
	input  wire         cfg_valid,
	output logic        cfg_ready
);
	import dhtc_pkg::*;

	typedef enum logic [4:0] {
		SEQ_IDLE  = 5'b00001,
		SEQ_SCALE = 5'b00010,
		SEQ_CHECK = 5'b00100,
		SEQ_DIV   = 5'b01000,
		SEQ_DONE  = 5'b10000
	} seq_t;

	seq_t         seq_q;
	logic [10:0]  target_q;
	logic [7:0]   band_q;
	logic [10:0]  hb_limit_q;
	logic [10:0]  ch_limit_q;
	logic [22:0]  drying_q;

	dryer_state_t mode_state_q;
	logic         run_q;
	logic         heater_q;
	logic [31:0]  start_ms_q;
	logic [22:0]  remaining_q;
	logic [6:0]   progress_q;
	logic [11:0]  ch_temp_q;
	logic [31:0]  delta_q;
	logic [22:0]  elapsed_q;
	logic         out_valid_q;
	logic [39:0]  out_data_q;

	div_req_t     div_req;
	div_stat_t    div_stat;
	logic [QUO_W-1:0] div_quo;

	logic         in_fire;
	logic         out_free;
	mode_t        in_mode;
	logic [31:0]  in_now;
	logic [11:0]  in_ch;
	logic [11:0]  in_hb;
	logic         unsafe;
	logic [31:0]  delta_ms;
	logic [60:0]  recip_prod;
	logic         time_up;
	logic [29:0]  scaled;
	logic         heat_low;
	logic         heat_high;

	assign s_axis_tready = (seq_q == SEQ_IDLE);
	assign cfg_ready     = 1'b1;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	assign in_mode = mode_t'(s_axis_tuser);
	assign in_now  = s_axis_tdata[31:0];
	assign in_ch   = s_axis_tdata[43:32];
	assign in_hb   = s_axis_tdata[55:44];

	assign unsafe = !s_axis_tdata[56] || !s_axis_tdata[57]
		|| ($signed({in_hb[11], in_hb}) >= $signed({2'b00, hb_limit_q}))
		|| ($signed({in_ch[11], in_ch}) >= $signed({2'b00, ch_limit_q}));

	assign delta_ms   = in_now - start_ms_q;
	// whole seconds by reciprocal multiplication
	assign recip_prod = {29'd0, delta_q} * 61'(MS_RECIP);
	assign time_up    = (elapsed_q >= drying_q);
	// elapsed * 100 as shifts and adds
	assign scaled     = ({7'd0, elapsed_q} << 6) + ({7'd0, elapsed_q} << 5)
		+ ({7'd0, elapsed_q} << 2);

	assign heat_low  = $signed({ch_temp_q[11], ch_temp_q})
		<= ($signed({2'b00, target_q}) - $signed({5'd0, band_q}));
	assign heat_high = $signed({ch_temp_q[11], ch_temp_q})
		>= ($signed({2'b00, target_q}) + $signed({5'd0, band_q}));

	always_comb begin
		div_req.start    = (seq_q == SEQ_CHECK) && !time_up;
		div_req.dividend = DIV_W'(scaled);
		div_req.divisor  = DIV_W'({drying_q, {(PCT_W - 1){1'b0}}});
		div_req.steps    = CNT_W'(PCT_W);
	end

	dhtc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q   <= 11'd500;
			band_q     <= 8'd20;
			hb_limit_q <= 11'd1100;
			ch_limit_q <= 11'd800;
			drying_q   <= 23'd14400;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TARGET_TEMP:     target_q   <= cfg_data[10:0];
				REG_HYSTERESIS_BAND: band_q     <= cfg_data[7:0];
				REG_HEATBED_LIMIT:   hb_limit_q <= cfg_data[10:0];
				REG_CHAMBER_LIMIT:   ch_limit_q <= cfg_data[10:0];
				REG_DRYING_SECONDS:  drying_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			ch_temp_q <= in_ch;
			delta_q   <= delta_ms;
		end
		if (seq_q == SEQ_SCALE) begin
			elapsed_q <= recip_prod[MS_RECIP_SHIFT +: 23];
		end
		if (seq_q == SEQ_DONE && out_free) begin
			out_data_q <= {6'd0, progress_q, remaining_q, run_q, heater_q,
				mode_state_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q        <= SEQ_IDLE;
			mode_state_q <= DRY_IDLE;
			run_q        <= 1'b0;
			heater_q     <= 1'b0;
			start_ms_q   <= '0;
			remaining_q  <= '0;
			progress_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			// hold a result until taken, load the next one from the done step
			out_valid_q <= (seq_q == SEQ_DONE && out_free) || (out_valid_q && !m_axis_tready);
			case (seq_q)
				SEQ_IDLE: begin
					if (in_fire) begin
						case (in_mode)
							MODE_START: begin
								run_q        <= 1'b1;
								start_ms_q   <= in_now;
								remaining_q  <= drying_q;
								progress_q   <= '0;
								mode_state_q <= DRY_DRYING;
								seq_q        <= SEQ_DONE;
							end
							MODE_STOP: begin
								run_q        <= 1'b0;
								heater_q     <= 1'b0;
								mode_state_q <= DRY_IDLE;
								seq_q        <= SEQ_DONE;
							end
							MODE_UPDATE: begin
								if (unsafe) begin
									run_q        <= 1'b0;
									heater_q     <= 1'b0;
									mode_state_q <= DRY_ERROR;
									seq_q        <= SEQ_DONE;
								end else if (run_q) begin
									seq_q <= SEQ_SCALE;
								end else begin
									heater_q <= 1'b0;
									seq_q    <= SEQ_DONE;
								end
							end
							default: seq_q <= SEQ_DONE;
						endcase
					end
				end
				SEQ_SCALE: begin
					seq_q <= SEQ_CHECK;
				end
				SEQ_CHECK: begin
					if (time_up) begin
						remaining_q  <= '0;
						progress_q   <= PCT_W'(FULL_PERCENT);
						run_q        <= 1'b0;
						heater_q     <= 1'b0;
						mode_state_q <= DRY_FINISHED;
						seq_q        <= SEQ_DONE;
					end else begin
						remaining_q <= drying_q - elapsed_q;
						seq_q       <= SEQ_DIV;
					end
				end
				SEQ_DIV: begin
					if (div_stat.done) begin
						progress_q <= div_quo[PCT_W-1:0];
						// hysteresis: switch on below the band, off above it
						if (heat_low) begin
							heater_q <= 1'b1;
						end else if (heat_high) begin
							heater_q <= 1'b0;
						end
						seq_q <= SEQ_DONE;
					end
				end
				SEQ_DONE: begin
					if (out_free) begin
						seq_q <= SEQ_IDLE;
					end
				end
				default: seq_q <= SEQ_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule
`default_nettype wire

// File: design/dhtc_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on dhtc_pkg for the request and status structs.
`default_nettype none
module dhtc_div (
	input  wire                         clk,
	input  wire                         arst_n,
	input  dhtc_pkg::div_req_t          req,
	output dhtc_pkg::div_stat_t         stat,
	output logic [dhtc_pkg::QUO_W-1:0]  quotient
);
	import dhtc_pkg::*;

	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] dsh_q;
	logic [QUO_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             ge;

	assign ge = (rem_q >= dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= req.steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.dividend;
			dsh_q <= req.divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			// subtract where it fits, shift the divisor down a place
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[QUO_W-2:0], ge};
			dsh_q <= {1'b0, dsh_q[DIV_W-1:1]};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule
`default_nettype wire
